/* hdl/i8gap_pkg.sv */
`timescale 1ns / 1ps
package i8gap_pkg;

  // Field and register widths
  localparam int CC_W    = 11;
  localparam int AREA_W  = 13;
  localparam int SCALE_W = 16;
  localparam int OUT_W   = 8;
  localparam int IDX_W   = 10;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Default sizes
  localparam int DEF_MAX_CHANNELS = 1024;
  localparam int DEF_MAX_AREA     = 4096;

  // Register reset values
  localparam logic [CC_W-1:0]    CC_RESET    = 11'd1024;
  localparam logic [AREA_W-1:0]  AREA_RESET  = 13'd27;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd1;

  // Output saturation bounds
  localparam logic signed [OUT_W-1:0] OUT_MAX = 8'sd127;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -8'sd128;
  localparam logic [OUT_W-1:0]        OUT_MAX_MAG = 8'd127;
  localparam logic [OUT_W-1:0]        OUT_MIN_MAG = 8'd128;

  // Quotient bits resolved by the divider, plus one overflow step
  localparam logic [3:0] DIV_STEPS = 4'd8;

  // Register map, word index
  typedef enum logic [1:0] {
    REG_CHANNEL_COUNT = 2'd0,
    REG_AREA          = 2'd1,
    REG_SCALE         = 2'd2
  } reg_idx_t;

endpackage

/* hdl/int8_global_average_pool.sv */
`timescale 1ns / 1ps
// A non-final-position item updates its channel sum in the cycle after its acceptance.
// One item per cycle is taken while positions before the last stream in and the engine is idle.
// An item of the last position runs the scale multiply and a 9-step shift-subtract divider
// (cut short when the quotient saturates) through states ABS, MUL, PREP, DIV and DONE, and
// input is held until the engine is idle. The sum memory's single read port sets the 1/cycle.
// Reset (rst_n low, synchronous): registers to 1024 channels, area 27, scale 1, counters zero.
module int8_global_average_pool #(
  parameter int MAX_CHANNELS = i8gap_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_AREA     = i8gap_pkg::DEF_MAX_AREA
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input item channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [i8gap_pkg::OUT_W-1:0]   in_sample,
  // result item channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [i8gap_pkg::OUT_W-1:0]   out_avg_value,
  output logic [i8gap_pkg::IDX_W-1:0]          out_channel_index,
  output logic                                 out_last,
  // configuration port
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [i8gap_pkg::PADDR_W-1:0]        cfg_paddr,
  input  logic [i8gap_pkg::PDATA_W-1:0]        cfg_pwdata,
  output logic [i8gap_pkg::PDATA_W-1:0]        cfg_prdata,
  output logic                                 cfg_pready
);
  import i8gap_pkg::*;

  // Derived widths
  localparam int CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int POS_W   = (MAX_AREA > 1) ? $clog2(MAX_AREA) : 1;
  localparam int CHE_W   = (CH_W + 1 > CC_W) ? CH_W + 1 : CC_W;
  localparam int ARE_W   = (POS_W + 1 > AREA_W) ? POS_W + 1 : AREA_W;
  localparam int SUM_W   = POS_W + 9;          // room for 128 * MAX_AREA with sign
  localparam int MAG_W   = SUM_W;
  localparam int PROD_W  = MAG_W + SCALE_W;
  localparam int N_W     = PROD_W + 2;         // 2 * product + area
  localparam int DV_W    = (N_W > ARE_W + 10) ? N_W : ARE_W + 10;

  // Engine states for the final-position divide
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ABS  = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_PREP = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_DONE = 6'b100000
  } eng_state_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CC_W-1:0]    channel_count_r;
  logic [AREA_W-1:0]  area_r;
  logic [SCALE_W-1:0] scale_r;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_count_r <= CC_RESET;
      area_r          <= AREA_RESET;
      scale_r         <= SCALE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CHANNEL_COUNT: channel_count_r <= cfg_pwdata[CC_W-1:0];
        REG_AREA:          area_r          <= cfg_pwdata[AREA_W-1:0];
        REG_SCALE:         scale_r         <= cfg_pwdata[SCALE_W-1:0];
        default: ;  // beyond the map: only the counters restart
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CHANNEL_COUNT: cfg_prdata = PDATA_W'(channel_count_r);
      REG_AREA:          cfg_prdata = PDATA_W'(area_r);
      REG_SCALE:         cfg_prdata = PDATA_W'(scale_r);
      default:           cfg_prdata = '0;
    endcase
  end

  // Clamp the map geometry to what the storage supports; zero means one
  logic [CHE_W-1:0] eff_ch;
  logic [ARE_W-1:0] eff_area;

  always_comb begin
    if (channel_count_r == '0) begin
      eff_ch = CHE_W'(1);
    end else if (CHE_W'(channel_count_r) > CHE_W'(MAX_CHANNELS)) begin
      eff_ch = CHE_W'(MAX_CHANNELS);
    end else begin
      eff_ch = CHE_W'(channel_count_r);
    end
    if (area_r == '0) begin
      eff_area = ARE_W'(1);
    end else if (ARE_W'(area_r) > ARE_W'(MAX_AREA)) begin
      eff_area = ARE_W'(MAX_AREA);
    end else begin
      eff_area = ARE_W'(area_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Position and channel counters
  // ---------------------------------------------------------------------------
  eng_state_t       eng_state_r, eng_state_nxt;
  logic [CH_W-1:0]  ch_cnt_r, ch_cnt_nxt;
  logic [POS_W-1:0] pos_cnt_r, pos_cnt_nxt;
  logic             in_accept;
  logic             ch_wrap;
  logic             pos_final;
  logic             s1_valid_r;
  logic             s1_final_r;

  // Hold the input while the engine works, and for the cycle a final-position
  // item spends in the sum stage so the engine is free when it arrives.
  assign in_stall  = (eng_state_r != ST_IDLE) || (s1_valid_r && s1_final_r);
  assign in_accept = in_valid && !in_stall;

  assign ch_wrap   = (CHE_W'(ch_cnt_r) + CHE_W'(1)) >= eff_ch;
  assign pos_final = (ARE_W'(pos_cnt_r) + ARE_W'(1)) >= eff_area;

  always_comb begin
    ch_cnt_nxt  = ch_cnt_r;
    pos_cnt_nxt = pos_cnt_r;
    if (cfg_wr) begin
      // any register write abandons a map in progress
      ch_cnt_nxt  = '0;
      pos_cnt_nxt = '0;
    end else if (in_accept) begin
      if (ch_wrap) begin
        ch_cnt_nxt  = '0;
        pos_cnt_nxt = pos_final ? '0 : pos_cnt_r + 1'b1;
      end else begin
        ch_cnt_nxt  = ch_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_cnt_r  <= '0;
      pos_cnt_r <= '0;
    end else begin
      ch_cnt_r  <= ch_cnt_nxt;
      pos_cnt_r <= pos_cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Sum stage: read the channel sum at acceptance, add, write back next cycle
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] sums_mem [MAX_CHANNELS];
  logic signed [SUM_W-1:0] rd_r;
  logic signed [OUT_W-1:0] s1_sample_r;
  logic [CH_W-1:0]         s1_ch_r;
  logic                    s1_first_r;
  logic                    s1_last_r;
  logic                    fwd_valid_r;
  logic [CH_W-1:0]         fwd_addr_r;
  logic signed [SUM_W-1:0] fwd_data_r;
  logic signed [SUM_W-1:0] sum_base;
  logic signed [SUM_W-1:0] sum_nxt;

  always_ff @(posedge clk) begin
    rd_r <= sums_mem[ch_cnt_r];
    if (s1_valid_r) begin
      sums_mem[s1_ch_r] <= sum_nxt;
    end
  end

  // The read for an item issues on the edge that writes the previous item,
  // so with one channel it sees the stale word: forward the fresh sum.
  assign sum_base = (fwd_valid_r && (fwd_addr_r == s1_ch_r)) ? fwd_data_r : rd_r;
  assign sum_nxt  = s1_first_r
                    ? {{(SUM_W-OUT_W){s1_sample_r[OUT_W-1]}}, s1_sample_r}
                    : sum_base + {{(SUM_W-OUT_W){s1_sample_r[OUT_W-1]}}, s1_sample_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= in_accept;
      fwd_valid_r <= s1_valid_r;
    end
    if (in_accept) begin
      s1_sample_r <= in_sample;
      s1_ch_r     <= ch_cnt_r;
      s1_first_r  <= (pos_cnt_r == '0);
      s1_final_r  <= pos_final;
      s1_last_r   <= ch_wrap;
    end
    fwd_addr_r <= s1_ch_r;
    fwd_data_r <= sum_nxt;
  end

  // ---------------------------------------------------------------------------
  // Engine: magnitude, scale multiply, rounded divide by area, saturate
  // q = (2 * |sum| * scale + area) / (2 * area), halves away from zero
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] sum_r;
  logic [MAG_W-1:0]        mag_r;
  logic                    neg_r;
  logic [PROD_W-1:0]       prod_r;
  logic [DV_W-1:0]         rem_r;
  logic [DV_W-1:0]         dsh_r;
  logic [3:0]              step_r;
  logic [OUT_W-1:0]        q_r;
  logic                    sat_r;
  logic [CH_W-1:0]         eng_ch_r;
  logic                    eng_last_r;
  logic                    rem_ge;
  logic                    out_load;
  logic signed [OUT_W-1:0] result;

  assign rem_ge   = rem_r >= dsh_r;
  assign out_load = (eng_state_r == ST_DONE) && (!out_valid || !out_stall);

  always_comb begin
    eng_state_nxt = eng_state_r;
    unique case (eng_state_r)
      ST_IDLE: if (s1_valid_r && s1_final_r) eng_state_nxt = ST_ABS;
      ST_ABS:  eng_state_nxt = ST_MUL;
      ST_MUL:  eng_state_nxt = ST_PREP;
      ST_PREP: eng_state_nxt = ST_DIV;
      ST_DIV: begin
        // overflow step: quotient of 256 or more saturates at once
        if ((step_r == DIV_STEPS) && rem_ge) eng_state_nxt = ST_DONE;
        else if (step_r == '0)               eng_state_nxt = ST_DONE;
      end
      ST_DONE: if (out_load) eng_state_nxt = ST_IDLE;
      default: eng_state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eng_state_r <= ST_IDLE;
    end else begin
      eng_state_r <= eng_state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (eng_state_r)
      ST_IDLE: begin
        sum_r      <= sum_nxt;
        eng_ch_r   <= s1_ch_r;
        eng_last_r <= s1_last_r;
      end
      ST_ABS: begin
        neg_r <= sum_r[SUM_W-1];
        mag_r <= sum_r[SUM_W-1] ? MAG_W'(~sum_r + 1'b1) : MAG_W'(sum_r);
      end
      ST_MUL: begin
        prod_r <= PROD_W'(mag_r) * PROD_W'(scale_r);
      end
      ST_PREP: begin
        rem_r  <= DV_W'({prod_r, 1'b0}) + DV_W'(eff_area);
        dsh_r  <= DV_W'({eff_area, 1'b0}) << DIV_STEPS;
        step_r <= DIV_STEPS;
        q_r    <= '0;
        sat_r  <= 1'b0;
      end
      ST_DIV: begin
        if (step_r == DIV_STEPS) begin
          sat_r <= rem_ge;
        end else begin
          q_r <= {q_r[OUT_W-2:0], rem_ge};
          if (rem_ge) rem_r <= rem_r - dsh_r;
        end
        dsh_r  <= dsh_r >> 1;
        step_r <= step_r - 1'b1;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_comb begin
    if (neg_r) begin
      if (sat_r || (q_r > OUT_MIN_MAG)) result = OUT_MIN;
      else                              result = $signed(8'd0 - q_r);
    end else begin
      if (sat_r || (q_r > OUT_MAX_MAG)) result = OUT_MAX;
      else                              result = $signed(q_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_avg_r;
  logic [IDX_W-1:0]        out_idx_r;
  logic                    out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_avg_r  <= result;
      out_idx_r  <= IDX_W'(eng_ch_r);
      out_last_r <= eng_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_avg_value     = out_avg_r;
  assign out_channel_index = out_idx_r;
  assign out_last          = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_final_finds_engine_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_final_r) |-> (eng_state_r == ST_IDLE))
    else $error("final-position item reached a busy engine");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(eng_state_r == ST_DONE))
    else $error("result raised without a finished divide");

  a_div_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (eng_state_r == ST_DIV) |-> (step_r <= DIV_STEPS))
    else $error("divider step out of range");

  a_channel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CHE_W'(ch_cnt_r) < eff_ch))
    else $error("channel counter beyond channel count");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import i8gap_pkg::*;

  // Bench timing
  localparam int DRAIN_CYCLES   = 24;    // settle time, covering a last-position item's pass through the engine
  localparam int HOLDOFF_CYCLES = 300;   // long receiver hold-off to back up the pipe
  localparam int HOLD_AT        = 200;   // results taken before the hold-off starts
  localparam int WATCHDOG_LIMIT = 5000;  // quiet cycles before the run is declared hung
  localparam int MAX_BURST      = 40;
  localparam int MAX_GAP        = 12;
  localparam logic [1:0] REG_SPARE = 2'd3;  // word index past the end of the register map

  // Sample content mixes for generated maps
  typedef enum logic [1:0] {
    MIX_WIDE,
    MIX_EXTREME,
    MIX_SMALL,
    MIX_FLOOR
  } sample_mix_t;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_COMB,
    RX_CHOKE
  } rx_mode_t;

  // One expected pooled result
  typedef struct packed {
    logic [OUT_W-1:0] avg;
    logic [IDX_W-1:0] chan;
    logic             last;
  } pooled_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_valid  = 1'b0;
  logic                    in_stall;
  logic signed [OUT_W-1:0] in_sample = '0;

  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [OUT_W-1:0] out_avg_value;
  logic [IDX_W-1:0]        out_channel_index;
  logic                    out_last;

  logic                    cfg_psel    = 1'b0;
  logic                    cfg_penable = 1'b0;
  logic                    cfg_pwrite  = 1'b0;
  logic [PADDR_W-1:0]      cfg_paddr   = '0;
  logic [PDATA_W-1:0]      cfg_pwdata  = '0;
  logic [PDATA_W-1:0]      cfg_prdata;
  logic                    cfg_pready;

  // Pending input items and expected results
  logic signed [OUT_W-1:0] pend_q [$];
  pooled_t                 exp_q [$];
  int                      err_count = 0;

  // Predictor state
  int m_cc;
  int m_area;
  int m_scale;
  int m_ch;
  int m_pos;
  int m_sums [DEF_MAX_CHANNELS];

  // Driver, receiver and watchdog state
  int       burst_left;
  int       gap_left;
  rx_mode_t rx_mode;
  int       rx_cyc;
  int       rx_count;
  int       hold_left;
  logic     hold_done;
  int       quiet;

  int8_global_average_pool #(
    .MAX_CHANNELS(DEF_MAX_CHANNELS),
    .MAX_AREA    (DEF_MAX_AREA)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_avg_value    (out_avg_value),
    .out_channel_index(out_channel_index),
    .out_last         (out_last),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] exp_v);
    $display("%0t %s: got %h, expected %h", $time, what, got_v, exp_v);
    err_count++;
  endtask

  // round(sum * mul / den), halves away from zero, saturated to int8
  function automatic logic [OUT_W-1:0] scaled_mean(input int sum, input int mul,
                                                   input int den);
    logic   neg;
    longint mag;
    longint q;
    neg = (sum < 0);
    mag = neg ? -longint'(sum) : longint'(sum);
    q   = (2 * mag * longint'(mul) + longint'(den)) / (2 * longint'(den));
    if (neg) begin
      if (q > 128) return OUT_MIN;
      return OUT_W'(-q);
    end
    if (q > 127) return OUT_MAX;
    return OUT_W'(q);
  endfunction

  function automatic void model_config(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
    unique case (idx)
      REG_CHANNEL_COUNT: m_cc    = int'(val[CC_W-1:0]);
      REG_AREA:          m_area  = int'(val[AREA_W-1:0]);
      REG_SCALE:         m_scale = int'(val[SCALE_W-1:0]);
      default: ;
    endcase
    // any write restarts the map
    m_ch  = 0;
    m_pos = 0;
  endfunction

  function automatic void model_step(input logic signed [OUT_W-1:0] smp);
    int      nch;
    int      nar;
    int      ch;
    pooled_t res;
    nch = (m_cc == 0) ? 1 : ((m_cc > DEF_MAX_CHANNELS) ? DEF_MAX_CHANNELS : m_cc);
    nar = (m_area == 0) ? 1 : ((m_area > DEF_MAX_AREA) ? DEF_MAX_AREA : m_area);
    ch  = m_ch;
    if (ch >= nch) ch = 0;
    if (m_pos == 0) m_sums[ch] = int'(smp);
    else            m_sums[ch] = m_sums[ch] + int'(smp);
    if (m_pos + 1 >= nar) begin
      res.avg  = scaled_mean(m_sums[ch], m_scale, nar);
      res.chan = IDX_W'(ch);
      res.last = (ch + 1 == nch);
      exp_q.push_back(res);
    end
    ch++;
    if (ch >= nch) begin
      ch = 0;
      m_pos++;
      if (m_pos >= nar) m_pos = 0;
    end
    m_ch = ch;
  endfunction

  // Driver: bursts of random length with random gaps between them
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pend_q.size() > 0) begin
        in_valid  <= 1'b1;
        in_sample <= pend_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= int'($urandom_range(1, MAX_BURST));
          gap_left   <= int'($urandom_range(0, MAX_GAP));
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: own stall pattern, plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_mode   <= RX_OPEN;
      rx_cyc    <= 0;
      rx_count  <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      rx_cyc <= rx_cyc + 1;
      if (out_valid && !out_stall) rx_count <= rx_count + 1;
      if ((rx_cyc % 64) == 63) rx_mode <= rx_mode_t'($urandom_range(0, 3));
      if (!hold_done && (rx_count >= HOLD_AT)) begin
        hold_left <= HOLDOFF_CYCLES;
        hold_done <= 1'b1;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        case (rx_mode)
          RX_OPEN:  out_stall <= 1'b0;
          RX_COIN:  out_stall <= ($urandom_range(0, 1) == 1);
          RX_COMB:  out_stall <= ((rx_cyc % 3) == 0);
          RX_CHOKE: out_stall <= ($urandom_range(0, 7) != 0);
          default:  out_stall <= 1'b0;
        endcase
      end
    end
  end

  // Monitor: predict on accepted items and writes, check accepted results
  always @(posedge clk) begin
    pooled_t got_item;
    pooled_t exp_item;
    if (!rst_n) begin
      m_cc    = int'(CC_RESET);
      m_area  = int'(AREA_RESET);
      m_scale = int'(SCALE_RESET);
      m_ch    = 0;
      m_pos   = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        model_config(cfg_paddr[3:2], cfg_pwdata);
      end
      if (in_valid && !in_stall) model_step(in_sample);
      if (out_valid && !out_stall) begin
        got_item = pooled_t'({out_avg_value, out_channel_index, out_last});
        if (exp_q.size() == 0) begin
          report_mismatch("unexpected result", 32'(got_item), '0);
        end else begin
          exp_item = exp_q.pop_front();
          if (got_item !== exp_item) begin
            report_mismatch("result", 32'(got_item), 32'(exp_item));
          end
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("int8_global_average_pool: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic cfg_check(input logic [1:0] idx, input logic [PDATA_W-1:0] want);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== want) report_mismatch("register read", cfg_prdata, want);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic push_items(input int count, input sample_mix_t mix);
    logic signed [OUT_W-1:0] smp;
    for (int k = 0; k < count; k++) begin
      case (mix)
        MIX_WIDE:    smp = OUT_W'($urandom_range(0, 255));
        MIX_EXTREME: smp = ($urandom_range(0, 1) == 0) ? OUT_MAX : OUT_MIN;
        MIX_SMALL:   smp = OUT_W'(int'($urandom_range(0, 6)) - 3);
        MIX_FLOOR:   smp = ($urandom_range(0, 7) == 0) ? OUT_MIN + 8'sd1 : OUT_MIN;
        default:     smp = '0;
      endcase
      pend_q.push_back(smp);
    end
  endtask

  // Wait until every item is taken and every result checked, then settle
  task automatic wait_idle();
    @(negedge clk);
    while ((pend_q.size() != 0) || in_valid || (exp_q.size() != 0)) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_map(input int chans, input int positions, input int mult);
    cfg_write(REG_CHANNEL_COUNT, PDATA_W'(chans));
    cfg_write(REG_AREA, PDATA_W'(positions));
    cfg_write(REG_SCALE, PDATA_W'(mult));
    cfg_check(REG_CHANNEL_COUNT, PDATA_W'(chans));
    cfg_check(REG_AREA, PDATA_W'(positions));
    cfg_check(REG_SCALE, PDATA_W'(mult));
    @(posedge clk);
  endtask

  task automatic run_phase(input int chans, input int positions, input int mult,
                           input int count, input sample_mix_t mix);
    set_map(chans, positions, mult);
    push_items(count, mix);
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);

    run_phase(1, 1, 1, 30, MIX_WIDE);
    run_phase(1, 5, 3, 40, MIX_WIDE);
    run_phase(4, 16, 1, 128, MIX_EXTREME);
    run_phase(3, 7, 65535, 84, MIX_SMALL);
    run_phase(0, 0, 0, 20, MIX_WIDE);
    run_phase(5, 9, 200, 45, MIX_FLOOR);

    // abandon a map part way, restart it through a write past the map
    run_phase(6, 4, 7, 13, MIX_WIDE);
    cfg_write(REG_SPARE, '0);
    @(posedge clk);
    push_items(48, MIX_WIDE);
    wait_idle();

    // area beyond the storage, left unfinished
    run_phase(1, 5000, 1, 30, MIX_WIDE);
    run_phase(2, 2, 5, 88, MIX_FLOOR);
    // channel count beyond the storage
    run_phase(1500, 1, 2, 1024, MIX_WIDE);

    if (err_count == 0) $display("int8_global_average_pool: match");
    else                $display("int8_global_average_pool: mismatch");
    $finish;
  end

endmodule

/* files.f */
hdl/i8gap_pkg.sv
hdl/int8_global_average_pool.sv
bench/tb_top.sv
